// ===== rtl/ulid_b32_pkg.sv =====
// Shared types, constants and character tables for the ULID base32 codec.
`timescale 1ns / 1ps

package ulid_b32_pkg;

  // Text and identifier geometry
  localparam int unsigned IdWidth     = 128;
  localparam int unsigned DigitWidth  = 5;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned TextLen     = 26;
  localparam int unsigned QueueDepth  = 2;
  localparam logic [CountWidth-1:0] CountMax = 5'd31;

  // Function codes on the input side
  typedef enum logic {
    FuncParse  = 1'b0,
    FuncFormat = 1'b1
  } func_e;

  // Result kinds on the output side
  typedef enum logic {
    KindParse = 1'b0,
    KindChar  = 1'b1
  } kind_e;

  // Decoded character: digit value and whether the byte is a digit at all
  typedef struct packed {
    logic                  ok;
    logic [DigitWidth-1:0] val;
  } dec_t;

  // Transaction handed from front to back
  typedef struct packed {
    func_e              op;
    logic               ok;
    logic [IdWidth-1:0] data;
  } cmd_t;

  // Case-insensitive Crockford decode; I/L read as one, O as zero, U is not a digit
  function automatic dec_t decode_char(logic [7:0] c);
    logic [7:0] u;
    dec_t       r;
    u = ((c >= "a") && (c <= "z")) ? (c - 8'h20) : c;
    r.ok = 1'b1;
    unique case (u)
      "0", "O": r.val = 5'd0;
      "1", "I", "L": r.val = 5'd1;
      "2": r.val = 5'd2;
      "3": r.val = 5'd3;
      "4": r.val = 5'd4;
      "5": r.val = 5'd5;
      "6": r.val = 5'd6;
      "7": r.val = 5'd7;
      "8": r.val = 5'd8;
      "9": r.val = 5'd9;
      "A": r.val = 5'd10;
      "B": r.val = 5'd11;
      "C": r.val = 5'd12;
      "D": r.val = 5'd13;
      "E": r.val = 5'd14;
      "F": r.val = 5'd15;
      "G": r.val = 5'd16;
      "H": r.val = 5'd17;
      "J": r.val = 5'd18;
      "K": r.val = 5'd19;
      "M": r.val = 5'd20;
      "N": r.val = 5'd21;
      "P": r.val = 5'd22;
      "Q": r.val = 5'd23;
      "R": r.val = 5'd24;
      "S": r.val = 5'd25;
      "T": r.val = 5'd26;
      "V": r.val = 5'd27;
      "W": r.val = 5'd28;
      "X": r.val = 5'd29;
      "Y": r.val = 5'd30;
      "Z": r.val = 5'd31;
      default: begin
        r.ok  = 1'b0;
        r.val = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Leading character must keep the value within 128 bits
  function automatic logic first_ok(logic [7:0] c);
    return (c <= "7") || (c == "l") || (c == "L") || (c == "i") || (c == "I") ||
           (c == "o") || (c == "O");
  endfunction

  // Upper-case Crockford encode
  function automatic logic [7:0] encode_digit(logic [DigitWidth-1:0] v);
    logic [7:0] r;
    unique case (v)
      5'd0:  r = "0";
      5'd1:  r = "1";
      5'd2:  r = "2";
      5'd3:  r = "3";
      5'd4:  r = "4";
      5'd5:  r = "5";
      5'd6:  r = "6";
      5'd7:  r = "7";
      5'd8:  r = "8";
      5'd9:  r = "9";
      5'd10: r = "A";
      5'd11: r = "B";
      5'd12: r = "C";
      5'd13: r = "D";
      5'd14: r = "E";
      5'd15: r = "F";
      5'd16: r = "G";
      5'd17: r = "H";
      5'd18: r = "J";
      5'd19: r = "K";
      5'd20: r = "M";
      5'd21: r = "N";
      5'd22: r = "P";
      5'd23: r = "Q";
      5'd24: r = "R";
      5'd25: r = "S";
      5'd26: r = "T";
      5'd27: r = "V";
      5'd28: r = "W";
      5'd29: r = "X";
      5'd30: r = "Y";
      default: r = "Z";
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ulid_b32_front.sv =====
// Front end: takes items, decodes and accumulates text, queues parse and format work.
`timescale 1ns / 1ps

module ulid_b32_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            func_i,
  input  logic [7:0]                      char_in_i,
  input  logic                            char_last_i,
  input  logic [47:0]                     id_time_i,
  input  logic [15:0]                     id_rand_hi_i,
  input  logic [63:0]                     id_rand_lo_i,
  output logic                            q_push_o,
  output ulid_b32_pkg::cmd_t              q_cmd_o
);

  logic [ulid_b32_pkg::IdWidth-1:0]    accum_q, accum_d;
  logic [ulid_b32_pkg::CountWidth-1:0] count_q, count_d;
  logic                                bad_q, bad_d;
  ulid_b32_pkg::dec_t                  dec;
  logic                                is_parse;
  logic                                text_ok;

  assign dec      = ulid_b32_pkg::decode_char(char_in_i);
  assign is_parse = (ulid_b32_pkg::func_e'(func_i) == ulid_b32_pkg::FuncParse);

  // Parse state update; a format item leaves it alone
  always_comb begin
    accum_d = accum_q;
    count_d = count_q;
    bad_d   = bad_q;
    text_ok = 1'b0;
    if (accept_i && is_parse) begin
      accum_d = {accum_q[ulid_b32_pkg::IdWidth-ulid_b32_pkg::DigitWidth-1:0], dec.val};
      count_d = (count_q == ulid_b32_pkg::CountMax) ? count_q : count_q + 5'd1;
      bad_d   = bad_q | ~dec.ok |
                ((count_q == '0) & ~ulid_b32_pkg::first_ok(char_in_i));
      text_ok = (count_d == ulid_b32_pkg::CountWidth'(ulid_b32_pkg::TextLen)) & ~bad_d;
    end
  end

  // Queue a transaction on a format item or on the last text character
  always_comb begin
    q_push_o     = accept_i & (~is_parse | char_last_i);
    q_cmd_o.op   = ulid_b32_pkg::func_e'(func_i);
    q_cmd_o.ok   = is_parse ? text_ok : 1'b1;
    if (is_parse) begin
      q_cmd_o.data = text_ok ? accum_d : '0;
    end else begin
      q_cmd_o.data = {id_time_i, id_rand_hi_i, id_rand_lo_i};
    end
  end

  // Text state registers; cleared after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
    end else if (accept_i && is_parse && char_last_i) begin
      accum_q <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      accum_q <= accum_d;
      count_q <= count_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// ===== rtl/ulid_b32_fifo.sv =====
// Small transaction queue between the front and back ends.
`timescale 1ns / 1ps

module ulid_b32_fifo #(
  parameter int unsigned Depth = ulid_b32_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ulid_b32_pkg::cmd_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output ulid_b32_pkg::cmd_t data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ulid_b32_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/ulid_b32_back.sv =====
// Back end: turns queued transactions into results through the output register.
`timescale 1ns / 1ps

module ulid_b32_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  ulid_b32_pkg::cmd_t q_cmd_i,
  output logic               q_pop_o,
  input  logic               pop,
  output logic               empty,
  output logic               kind_o,
  output logic [7:0]         text_char_o,
  output logic               last_o,
  output logic               valid_res_o,
  output logic [47:0]        out_time_o,
  output logic [15:0]        out_rand_hi_o,
  output logic [63:0]        out_rand_lo_o
);

  localparam int unsigned ShW = ulid_b32_pkg::IdWidth + 2;
  localparam int unsigned DW  = ulid_b32_pkg::DigitWidth;
  localparam int unsigned CW  = ulid_b32_pkg::CountWidth;

  // Character shifter for format runs
  logic [ShW-1:0] sh_q, sh_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           busy_q, busy_d;

  // Output register
  logic                             out_vld_q, out_vld_d;
  logic                             load;
  ulid_b32_pkg::kind_e              kind_q, kind_d;
  logic [7:0]                       char_q, char_d;
  logic                             last_q, last_d;
  logic                             ok_q, ok_d;
  logic [ulid_b32_pkg::IdWidth-1:0] data_q, data_d;
  logic                             adv;

  assign adv = ~out_vld_q | pop;

  // Sequencer: one result per cycle whenever the output slot frees up
  always_comb begin
    sh_d      = sh_q;
    idx_d     = idx_q;
    busy_d    = busy_q;
    out_vld_d = out_vld_q;
    load      = 1'b0;
    q_pop_o   = 1'b0;
    kind_d    = ulid_b32_pkg::KindChar;
    char_d    = '0;
    last_d    = 1'b0;
    ok_d      = 1'b1;
    data_d    = '0;
    if (adv) begin
      if (busy_q) begin
        load      = 1'b1;
        out_vld_d = 1'b1;
        char_d    = ulid_b32_pkg::encode_digit(sh_q[ShW-1 -: DW]);
        last_d    = (idx_q == CW'(ulid_b32_pkg::TextLen - 1));
        sh_d      = {sh_q[ShW-DW-1:0], {DW{1'b0}}};
        idx_d     = idx_q + CW'(1);
        if (last_d) begin
          busy_d = 1'b0;
        end
      end else if (!q_empty_i) begin
        load      = 1'b1;
        out_vld_d = 1'b1;
        q_pop_o   = 1'b1;
        if (q_cmd_i.op == ulid_b32_pkg::FuncFormat) begin
          // First character holds only the top three identifier bits
          char_d = ulid_b32_pkg::encode_digit({2'b00, q_cmd_i.data[ulid_b32_pkg::IdWidth-1 -: 3]});
          sh_d   = {q_cmd_i.data[ulid_b32_pkg::IdWidth-4:0], {DW{1'b0}}};
          idx_d  = CW'(1);
          busy_d = 1'b1;
        end else begin
          kind_d = ulid_b32_pkg::KindParse;
          last_d = 1'b1;
          ok_d   = q_cmd_i.ok;
          data_d = q_cmd_i.data;
        end
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (load) begin
      kind_q <= kind_d;
      char_q <= char_d;
      last_q <= last_d;
      ok_q   <= ok_d;
      data_q <= data_d;
    end
  end

  assign empty         = ~out_vld_q;
  assign kind_o        = kind_q;
  assign text_char_o   = char_q;
  assign last_o        = last_q;
  assign valid_res_o   = ok_q;
  assign out_time_o    = data_q[127:80];
  assign out_rand_hi_o = data_q[79:64];
  assign out_rand_lo_o = data_q[63:0];

endmodule

// ===== rtl/ulid_base32_codec_unit.sv =====
// Top level of the ULID Crockford base32 codec: front end, queue, back end.
`timescale 1ns / 1ps
// A parse result or the first formatted character is written to the queue at the accepting edge,
// then loaded into the output register and held there until popped. Throughput: one text
// character per cycle in while the queue is not full; an identifier streams 26 characters,
// one per cycle while popped, set by the back-end character shifter; no gap between identifiers.
// Input stalls only while the two-entry queue is full; results may wait on the output register.
// Reset (asynchronous, active low) clears the text state, the queue and the output register.

module ulid_base32_codec_unit #(
  parameter int unsigned QueueDepth = ulid_b32_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [7:0]  char_in_i,
  input  logic        char_last_i,
  input  logic [47:0] id_time_i,
  input  logic [15:0] id_rand_hi_i,
  input  logic [63:0] id_rand_lo_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  text_char_o,
  output logic        last_o,
  output logic        valid_res_o,
  output logic [47:0] out_time_o,
  output logic [15:0] out_rand_hi_o,
  output logic [63:0] out_rand_lo_o
);

  logic               accept;
  logic               q_push, q_pop, q_empty;
  ulid_b32_pkg::cmd_t q_in, q_out;

  assign accept = push & ~full;

  ulid_b32_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (func_i),
    .char_in_i    (char_in_i),
    .char_last_i  (char_last_i),
    .id_time_i    (id_time_i),
    .id_rand_hi_i (id_rand_hi_i),
    .id_rand_lo_i (id_rand_lo_i),
    .q_push_o     (q_push),
    .q_cmd_o      (q_in)
  );

  ulid_b32_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  ulid_b32_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_out),
    .q_pop_o       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .kind_o        (kind_o),
    .text_char_o   (text_char_o),
    .last_o        (last_o),
    .valid_res_o   (valid_res_o),
    .out_time_o    (out_time_o),
    .out_rand_hi_o (out_rand_hi_o),
    .out_rand_lo_o (out_rand_lo_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the ULID base32 codec: parse and format traffic with random stalls.
`timescale 1ns / 1ps

module testbench;

  // Run limits
  localparam int RandomItems = 380;
  localparam int IdleLimit   = 1000;
  localparam int DrainEvery  = 120;

  // Upper-case digit alphabet, digit 0 in the top byte
  localparam logic [8*32-1:0] B32Digits = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

  // One result as seen on the output ports
  typedef struct {
    ulid_b32_pkg::kind_e kind;
    logic [7:0]          ch;
    logic                fin;
    logic                ok;
    logic [47:0]         stamp;
    logic [15:0]         rhi;
    logic [63:0]         rlo;
  } codec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        func_i = 1'b0;
  logic [7:0]  char_in_i = 8'h00;
  logic        char_last_i = 1'b0;
  logic [47:0] id_time_i = '0;
  logic [15:0] id_rand_hi_i = '0;
  logic [63:0] id_rand_lo_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [7:0]  text_char_o;
  logic        last_o;
  logic        valid_res_o;
  logic [47:0] out_time_o;
  logic [15:0] out_rand_hi_o;
  logic [63:0] out_rand_lo_o;

  // Predictor state: text accumulator, character count, bad-text flag
  logic [127:0]  acc_bits = '0;
  logic [4:0]    text_count = '0;
  logic          text_bad = 1'b0;
  codec_result_t pending_results [$];

  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int pop_wait = 0;
  bit no_idle = 1'b0;

  ulid_base32_codec_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .char_in_i     (char_in_i),
    .char_last_i   (char_last_i),
    .id_time_i     (id_time_i),
    .id_rand_hi_i  (id_rand_hi_i),
    .id_rand_lo_i  (id_rand_lo_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .text_char_o   (text_char_o),
    .last_o        (last_o),
    .valid_res_o   (valid_res_o),
    .out_time_o    (out_time_o),
    .out_rand_hi_o (out_rand_hi_o),
    .out_rand_lo_o (out_rand_lo_o)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Digit value of a text byte, -1 when it is not a digit
  function automatic int digit_of(logic [7:0] c);
    logic [7:0] u;
    int         v;
    u = ((c >= "a") && (c <= "z")) ? (c - 8'h20) : c;
    v = -1;
    if ((c >= "0") && (c <= "9")) v = c - "0";
    else if ((u == "I") || (u == "L")) v = 1;
    else if (u == "O") v = 0;
    else begin
      for (int i = 10; i < 32; i++) begin
        if (B32Digits[8*(31-i) +: 8] == u) v = i;
      end
    end
    return v;
  endfunction

  // Leading byte must not push the value past 128 bits
  function automatic bit lead_ok(logic [7:0] c);
    logic [7:0] u;
    u = ((c >= "a") && (c <= "z")) ? (c - 8'h20) : c;
    return (c <= "7") || (u == "I") || (u == "L") || (u == "O");
  endfunction

  // Expected results for one accepted transaction
  task automatic predict_codec(input ulid_b32_pkg::func_e f, input logic [7:0] c,
                               input logic lst, input logic [127:0] id);
    codec_result_t r;
    int            d;
    logic [4:0]    dig;
    bit            ok;
    if (f == ulid_b32_pkg::FuncFormat) begin
      for (int k = 0; k < ulid_b32_pkg::TextLen; k++) begin
        dig     = 5'((id >> (125 - 5 * k)) & 128'h1F);
        r.kind  = ulid_b32_pkg::KindChar;
        r.ch    = B32Digits[8*(31-dig) +: 8];
        r.fin   = (k == ulid_b32_pkg::TextLen - 1);
        r.ok    = 1'b1;
        r.stamp = '0;
        r.rhi   = '0;
        r.rlo   = '0;
        pending_results.push_back(r);
      end
    end else begin
      d = digit_of(c);
      if (d < 0) text_bad = 1'b1;
      if ((text_count == 5'd0) && !lead_ok(c)) text_bad = 1'b1;
      acc_bits = {acc_bits[122:0], (d < 0) ? 5'd0 : 5'(d)};
      if (text_count != ulid_b32_pkg::CountMax) text_count = text_count + 5'd1;
      if (lst) begin
        ok      = (text_count == 5'(ulid_b32_pkg::TextLen)) && !text_bad;
        r.kind  = ulid_b32_pkg::KindParse;
        r.ch    = 8'h00;
        r.fin   = 1'b1;
        r.ok    = ok;
        r.stamp = ok ? acc_bits[127:80] : '0;
        r.rhi   = ok ? acc_bits[79:64] : '0;
        r.rlo   = ok ? acc_bits[63:0] : '0;
        pending_results.push_back(r);
        acc_bits   = '0;
        text_count = '0;
        text_bad   = 1'b0;
      end
    end
  endtask

  // Drive one transaction after a random gap and hold it until taken
  task automatic send_item(input ulid_b32_pkg::func_e f, input logic [7:0] c, input logic lst,
                           input logic [127:0] id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i       = f;
    char_in_i    = c;
    char_last_i  = lst;
    id_time_i    = id[127:80];
    id_rand_hi_i = id[79:64];
    id_rand_lo_i = id[63:0];
    push         = 1'b1;
    do @(posedge clk_i); while (full);
    predict_codec(f, c, lst, id);
    items_sent++;
  endtask

  function automatic logic [127:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic send_format(input logic [127:0] id);
    send_item(ulid_b32_pkg::FuncFormat, 8'($urandom), 1'($urandom), id);
  endtask

  // Send a text; a format transaction goes in before index fmt_at if that index lies within the text
  task automatic send_text(input logic [7:0] txt [$], input int fmt_at);
    for (int i = 0; i < txt.size(); i++) begin
      if (i == fmt_at) send_format(rand_id());
      send_item(ulid_b32_pkg::FuncParse, txt[i], i == txt.size() - 1, rand_id());
    end
  endtask

  task automatic send_string(input string s, input int fmt_at);
    logic [7:0] txt [$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text(txt, fmt_at);
  endtask

  // Pause the sender until every expected result is out
  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Text byte for a digit value, with random case and alias spelling
  function automatic logic [7:0] pick_char(logic [4:0] v);
    logic [7:0] c;
    c = B32Digits[8*(31-v) +: 8];
    if ((v == 5'd0) && ($urandom_range(0, 1) == 1)) begin
      c = ($urandom_range(0, 1) == 1) ? "O" : "o";
    end else if ((v == 5'd1) && ($urandom_range(0, 1) == 1)) begin
      case ($urandom_range(0, 3))
        0: c = "I";
        1: c = "i";
        2: c = "L";
        default: c = "l";
      endcase
    end else if ((c >= "A") && ($urandom_range(0, 1) == 1)) begin
      c = c + 8'h20;
    end
    return c;
  endfunction

  // Well-formed 26-character text with random content
  function automatic void make_text(output logic [7:0] txt [$]);
    txt.delete();
    txt.push_back(pick_char(5'($urandom_range(0, 7))));
    for (int i = 1; i < ulid_b32_pkg::TextLen; i++) begin
      txt.push_back(pick_char(5'($urandom_range(0, 31))));
    end
  endfunction

  // Format mode with all-zero, all-one and alternating identifiers
  task automatic test_format_extremes();
    send_format('0);
    send_format('1);
    send_format({64{2'b10}});
  endtask

  // One-character texts: undecodable bytes, a bad leading digit, a count short of 26
  task automatic test_parse_short();
    send_string("U", -1);
    send_string("u", -1);
    send_string("=", -1);
    send_string("8", -1);
    send_string("0", -1);
    send_item(ulid_b32_pkg::FuncParse, 8'hFF, 1'b1, '1);
    send_item(ulid_b32_pkg::FuncParse, 8'h80, 1'b1, '0);
  endtask

  // Largest valid text, mixed case, with a format transaction in the middle of it
  task automatic test_valid_text();
    send_string("7zzzzzzzzzzzzZZZZZZZZZZZZZ", 13);
  endtask

  // Mostly well-formed texts, plus formats, broken texts and noise
  task automatic test_random();
    logic [7:0] txt [$];
    int         sel;
    int         base;
    int         last_drain;
    base       = items_sent;
    last_drain = items_sent;
    while (items_sent - base < RandomItems) begin
      sel     = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 7) == 0);
      if (sel < 45) begin
        make_text(txt);
        send_text(txt, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 25) : -1);
      end else if (sel < 60) begin
        case ($urandom_range(0, 5))
          0: send_format('0);
          1: send_format('1);
          default: send_format(rand_id());
        endcase
      end else if (sel < 80) begin
        make_text(txt);
        case ($urandom_range(0, 2))
          0: txt[$urandom_range(0, ulid_b32_pkg::TextLen - 1)] = 8'($urandom);
          1: txt[0] = pick_char(5'($urandom_range(8, 31)));
          default: begin
            if ($urandom_range(0, 1) == 1) txt.pop_back();
            else repeat ($urandom_range(1, 8)) txt.push_back(pick_char(5'($urandom)));
          end
        endcase
        send_text(txt, -1);
      end else begin
        txt.delete();
        repeat ($urandom_range(1, 40)) txt.push_back(8'($urandom));
        send_text(txt, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : -1);
      end
      if (items_sent - last_drain > DrainEvery) begin
        wait_drained();
        last_drain = items_sent;
      end
    end
    no_idle = 1'b0;
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Result checker: compare each popped transaction with the oldest expectation
  always @(posedge clk_i) begin
    codec_result_t r;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result expected none actual kind %0d char %h", $time, kind_o,
                 text_char_o);
        mismatches++;
      end else begin
        r = pending_results.pop_front();
        check_field("kind", r.kind, kind_o);
        check_field("text_char", r.ch, text_char_o);
        check_field("last", r.fin, last_o);
        check_field("valid_res", r.ok, valid_res_o);
        check_field("out_time", r.stamp, out_time_o);
        check_field("out_rand_hi", r.rhi, out_rand_hi_o);
        check_field("out_rand_lo", r.rlo, out_rand_lo_o);
      end
      pop_wait = no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    if (pop_wait > 0) begin
      pop = 1'b0;
      pop_wait--;
    end else begin
      pop = 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("ulid_base32_codec_unit: mismatch");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_format_extremes();
    test_parse_short();
    test_valid_text();
    wait_drained();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("ulid_base32_codec_unit: match");
    end else begin
      $display("ulid_base32_codec_unit: mismatch");
    end
    $finish;
  end

endmodule
